/* hdl/xor_distance_kbucket_table_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the XOR-distance routing table.
// ---------------------------------------------------------------------------
`ifndef XOR_DISTANCE_KBUCKET_TABLE_MACROS_SVH
`define XOR_DISTANCE_KBUCKET_TABLE_MACROS_SVH

// A property checked at every clock edge outside reset.
`define KBT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed in the next cycle by another.
`define KBT_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

/* hdl/kbt_pkg.sv */
// ---------------------------------------------------------------------------
// kbt_pkg
// Types, sizes and codes shared by the routing table modules.
// ---------------------------------------------------------------------------
`default_nettype none

package kbt_pkg;

  localparam int BUCKET_SLOTS = 6;
  localparam int BUCKET_COUNT = 128;
  localparam int ENTRY_DEPTH  = BUCKET_COUNT * BUCKET_SLOTS;
  localparam int ENTRY_AW     = $clog2(ENTRY_DEPTH);
  localparam int SLOT_W       = $clog2(BUCKET_SLOTS + 1);
  localparam int FILL_AW      = $clog2(BUCKET_COUNT);
  localparam int BIDX_W       = 7;
  localparam int CFG_IDX_W    = 1;

  localparam logic [2:0] ST_APPENDED  = 3'd0;
  localparam logic [2:0] ST_REFRESHED = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_OWN       = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_MISSING   = 3'd5;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_HIGH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_LOW  = 1'd1;

  typedef struct packed {
    logic        op;
    logic [63:0] peer_id_high;
    logic [63:0] peer_id_low;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [BIDX_W-1:0] bucket_index;
    logic [31:0]       found_addr;
    logic [15:0]       found_port;
  } out_item_t;

  typedef struct packed {
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [31:0] addr;
    logic [15:0] port;
  } entry_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [FILL_AW-1:0] addr;
    logic [SLOT_W-1:0]  wr_data;
  } fill_req_t;

endpackage

`default_nettype wire

/* hdl/kbt_entry_ram.sv */
// ---------------------------------------------------------------------------
// kbt_entry_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module kbt_entry_ram #(
  parameter int DEPTH = 768,
  parameter int WIDTH = 176,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/kbt_fill_store.sv */
// ---------------------------------------------------------------------------
// kbt_fill_store
// Per-bucket fill counts in a memory, with one valid bit per bucket.
// ---------------------------------------------------------------------------
`default_nettype none

module kbt_fill_store
  import kbt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fill_req_t         req,
  output logic      [SLOT_W-1:0] fill
);

  logic [SLOT_W-1:0]       fill_mem [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] valid_r;
  logic [SLOT_W-1:0]       rd_data_r;
  logic                    rd_valid_r;

  // A bucket never written reads as empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      fill_mem[req.addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r  <= fill_mem[req.addr];
      rd_valid_r <= valid_r[req.addr];
    end
  end

  assign fill = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

/* hdl/kbt_ctrl.sv */
// ---------------------------------------------------------------------------
// kbt_ctrl
// Request sequencer: bucket selection, slot search, shift and write-back.
// ---------------------------------------------------------------------------
`default_nettype none

`include "xor_distance_kbucket_table_macros.svh"

module kbt_ctrl
  import kbt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [63:0] own_high,
  input  wire logic [63:0] own_low,
  input  wire logic        req_valid,
  input  wire in_item_t    req_item,
  output logic             req_ready,
  output logic             res_valid,
  output out_item_t        res_item,
  input  wire logic        res_ready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIST  = 3'd1;
  localparam logic [2:0] S_BIDX  = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_TAIL  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]          state_r, state_nxt;
  in_item_t            item_r;
  logic [127:0]        dist_r;
  logic                own_r;
  logic [2:0]          grp_r;
  logic [15:0]         word_r;
  logic [BIDX_W-1:0]   bidx_r;
  logic [ENTRY_AW-1:0] base_r;
  logic [SLOT_W-1:0]   rd_slot_r;
  logic [SLOT_W-1:0]   pslot_r;
  logic                pend_r;
  logic [SLOT_W-1:0]   tslot_r;
  logic                append_r;
  logic [31:0]         hit_addr_r;
  logic [15:0]         hit_port_r;
  out_item_t           res_r;

  logic [2:0]          grp_c;
  logic [3:0]          pos_c;
  logic [BIDX_W-1:0]   bidx_c;
  logic                beyond_c;
  logic [SLOT_W-1:0]   fill_q;
  logic                issue;
  logic                match;
  entry_t              rdata;
  logic [$bits(entry_t)-1:0] rdata_raw;
  logic                ent_rd_en;
  logic [ENTRY_AW-1:0] ent_rd_addr;
  logic                ent_wr_en;
  logic [ENTRY_AW-1:0] ent_wr_addr;
  entry_t              ent_wr_data;
  fill_req_t           fill_req;

  // Highest non-zero 16-bit group of the distance.
  always_comb begin
    grp_c = '0;
    for (int g = 0; g < 8; g++) begin
      if (|dist_r[g*16 +: 16]) begin
        grp_c = 3'(g);
      end
    end
  end

  // Highest set bit within the chosen group.
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < 16; i++) begin
      if (word_r[i]) begin
        pos_c = 4'(i);
      end
    end
  end

  assign bidx_c   = {grp_r, pos_c};
  assign beyond_c = {1'b0, bidx_c} >= (BIDX_W + 1)'(BUCKET_COUNT);

  assign rdata = entry_t'(rdata_raw);
  assign issue = rd_slot_r < fill_q;
  assign match = pend_r && (rdata.id_high == item_r.peer_id_high)
                        && (rdata.id_low == item_r.peer_id_low);

  always_comb begin
    ent_rd_en   = 1'b0;
    ent_rd_addr = base_r + ENTRY_AW'(rd_slot_r);
    ent_wr_en   = 1'b0;
    ent_wr_addr = base_r + ENTRY_AW'(pslot_r) - ENTRY_AW'(1);
    ent_wr_data = rdata;
    fill_req.rd_en   = (state_r == S_BIDX) && !own_r && !beyond_c;
    fill_req.wr_en   = 1'b0;
    fill_req.addr    = (state_r == S_BIDX) ? FILL_AW'(bidx_c) : FILL_AW'(bidx_r);
    fill_req.wr_data = fill_q + SLOT_W'(1);
    unique case (state_r)
      S_SRCH: begin
        ent_rd_en = issue;
      end
      S_SHIFT: begin
        ent_rd_en = issue;
        ent_wr_en = pend_r;
      end
      S_TAIL: begin
        ent_wr_en   = 1'b1;
        ent_wr_addr = base_r + ENTRY_AW'(tslot_r);
        ent_wr_data.id_high = item_r.peer_id_high;
        ent_wr_data.id_low  = item_r.peer_id_low;
        ent_wr_data.addr    = append_r ? item_r.peer_addr : hit_addr_r;
        ent_wr_data.port    = append_r ? item_r.peer_port : hit_port_r;
        fill_req.wr_en      = append_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (req_valid) state_nxt = S_DIST;
      S_DIST:  state_nxt = S_BIDX;
      S_BIDX:  state_nxt = (own_r || beyond_c) ? S_OUT : S_SRCH;
      S_SRCH: begin
        if (match) begin
          state_nxt = (item_r.op == OP_LOOKUP) ? S_OUT : S_SHIFT;
        end else if (!issue) begin
          if (item_r.op == OP_UPDATE && fill_q < SLOT_W'(BUCKET_SLOTS)) begin
            state_nxt = S_TAIL;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SHIFT: if (!issue && !pend_r) state_nxt = S_TAIL;
      S_TAIL:  state_nxt = S_OUT;
      S_OUT:   if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SRCH || state_r == S_SHIFT) begin
        pend_r <= issue;
      end else begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        item_r <= req_item;
        dist_r <= {req_item.peer_id_high ^ own_high, req_item.peer_id_low ^ own_low};
      end
      S_DIST: begin
        own_r  <= (dist_r == '0);
        grp_r  <= grp_c;
        word_r <= dist_r[grp_c*16 +: 16];
      end
      S_BIDX: begin
        bidx_r    <= bidx_c;
        base_r    <= ENTRY_AW'(bidx_c) * ENTRY_AW'(BUCKET_SLOTS);
        rd_slot_r <= '0;
        append_r  <= 1'b0;
        res_r.bucket_index <= own_r ? '0 : bidx_c;
        res_r.found_addr   <= '0;
        res_r.found_port   <= '0;
        if (own_r) begin
          res_r.status <= ST_OWN;
        end else begin
          res_r.status <= (item_r.op == OP_UPDATE) ? ST_FULL : ST_MISSING;
        end
      end
      S_SRCH: begin
        pslot_r <= rd_slot_r;
        if (issue) rd_slot_r <= rd_slot_r + SLOT_W'(1);
        if (match) begin
          hit_addr_r <= rdata.addr;
          hit_port_r <= rdata.port;
          tslot_r    <= fill_q - SLOT_W'(1);
          if (item_r.op == OP_LOOKUP) begin
            res_r.status     <= ST_FOUND;
            res_r.found_addr <= rdata.addr;
            res_r.found_port <= rdata.port;
          end else begin
            res_r.status <= ST_REFRESHED;
          end
        end else if (!issue) begin
          tslot_r <= fill_q;
          if (item_r.op == OP_LOOKUP) begin
            res_r.status <= ST_MISSING;
          end else if (fill_q < SLOT_W'(BUCKET_SLOTS)) begin
            res_r.status <= ST_APPENDED;
            append_r     <= 1'b1;
          end else begin
            res_r.status <= ST_FULL;
          end
        end
      end
      S_SHIFT: begin
        pslot_r <= rd_slot_r;
        if (issue) rd_slot_r <= rd_slot_r + SLOT_W'(1);
      end
      default: begin
      end
    endcase
  end

  kbt_entry_ram #(
    .DEPTH (ENTRY_DEPTH),
    .WIDTH ($bits(entry_t))
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_wr_addr),
    .wr_data (ent_wr_data),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (rdata_raw)
  );

  kbt_fill_store u_fill_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fill_req),
    .fill  (fill_q)
  );

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res_item  = res_r;

  // The shift reads two slots ahead of the one it writes, so the two never collide.
  `KBT_ASSERT(a_no_rw_clash, clk, rst_n, !(ent_rd_en && ent_wr_en && ent_rd_addr == ent_wr_addr), "entry read and write hit the same address")
  `KBT_ASSERT(a_fill_bound, clk, rst_n, !fill_req.wr_en || fill_req.wr_data <= SLOT_W'(BUCKET_SLOTS), "bucket fill beyond slot count")
  `KBT_ASSERT(a_found_zero, clk, rst_n, !res_valid || res_item.status == ST_FOUND || (res_item.found_addr == '0 && res_item.found_port == '0), "address reported without a hit")
  `KBT_ASSERT_NEXT(a_tail_done, clk, rst_n, state_r == S_TAIL, state_r == S_OUT && $past(ent_wr_en), "tail write not followed by result")

endmodule

`default_nettype wire

/* hdl/xor_distance_kbucket_table.sv */
// ---------------------------------------------------------------------------
// xor_distance_kbucket_table
// Routing table of 128 buckets of six peers, chosen by XOR distance.
// ---------------------------------------------------------------------------
// The in_ channel carries one request: an update (insert or refresh) or a
// lookup of a 128-bit peer ID. The out_ channel returns one result for each
// request: status, bucket index and, on a hit, the stored address and port.
// The own ID must be written through cfg_ only while the block is idle;
// the block does not enforce it. One request is processed at a time. The
// accepting cycle registers the XOR distance; the DIST and BIDX states
// select the bucket and read its fill count; SRCH reads occupied slots one
// by one through the single read port of the slot memory until a match.
// An append then writes the new entry at the tail (TAIL); a refresh first
// moves each later slot up (SHIFT), then writes the refreshed entry at the
// tail. The OUT state hands over the result. A new request is taken as soon
// as the previous result sits in the output register, even if not yet taken.
// A stalled receiver holds the output register; a second result then waits
// inside the block until it frees. Reset empties every bucket at once
// through per-bucket valid bits and clears the own ID to zero; no
// clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module xor_distance_kbucket_table
  import kbt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  logic [63:0] own_high_r;
  logic [63:0] own_low_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic        res_valid;
  logic        res_ready;
  out_item_t   res_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_high_r <= '0;
      own_low_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_HIGH: own_high_r <= cfg_data;
        CFG_OWN_LOW:  own_low_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res_item;
    end
  end

  kbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .own_high  (own_high_r),
    .own_low   (own_low_r),
    .req_valid (in_valid),
    .req_item  (in_data),
    .req_ready (in_ready),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_ready (res_ready)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
